[src/dips_pkg.sv]
package dips_pkg;

	// Fixed field widths
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 31;
	localparam int ADJ_W   = 22;
	localparam int DRIVE_W = 32;

	// Configuration port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	// Parameter defaults
	localparam int FRAC_BITS_DEF  = 10;
	localparam int SPEED_BITS_DEF = 16;
	localparam int SUM_BITS_DEF   = 48;

	// Register reset values
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd3584;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd20;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd12288;
	localparam logic [LIM_W-1:0]  SUM_LIMIT_RST  = 31'd3584000;

	// Register index (byte address / 4)
	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_SUM_LIMIT    = 3'd3,
		REG_LEFT_ENABLE  = 3'd4,
		REG_RIGHT_ENABLE = 3'd5
	} dips_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]  sum_limit;
		logic              left_enable;
		logic              right_enable;
	} dips_cfg_t;

	// Load strobes, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic out;
	} dips_adv_t;

endpackage

[src/dual_incremental_pid_speed.sv]
// Channel  | Signals                      | Content
// ---------+------------------------------+-------------------------------------------
// s_*      | s_tvalid s_tready s_tdata    | one control tick for both wheels
// m_*      | m_tvalid m_tready m_tdata    | adjustments and new drive values
// APB      | psel penable pwrite paddr .. | gains, sum limit, wheel enables
//
// One request is taken per cycle while s_tready is high; its result reaches m_*
// through the input, product, increment, sum and output registers in a row.
// The running sum is the only loop: one saturating add in the sum stage per cycle when that stage loads.
// Reset clears the sums, error history and pipeline valids and presets the registers.
// Each stage loads when it is empty or its successor takes its content, so a held
// result on m_* stalls only the stages behind it that are full.
module dual_incremental_pid_speed #(
	parameter int FRAC_BITS  = dips_pkg::FRAC_BITS_DEF,
	parameter int SPEED_BITS = dips_pkg::SPEED_BITS_DEF,
	parameter int SUM_BITS   = dips_pkg::SUM_BITS_DEF,
	parameter int IN_W       = ((4 * SPEED_BITS + 2 * dips_pkg::DRIVE_W + 7) / 8) * 8,
	parameter int OUT_W      = ((2 * dips_pkg::ADJ_W + 2 * dips_pkg::DRIVE_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dips_pkg::ADDR_W-1:0] paddr,
	input  logic [dips_pkg::DATA_W-1:0] pwdata,
	output logic [dips_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// left_target, left_measured, right_target, right_measured, left_drive_in,
	// right_drive_in, zero pad
	input  logic [IN_W-1:0]             s_tdata,
	// Output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// left_adjust, right_adjust, left_drive_out, right_drive_out, zero pad
	output logic [OUT_W-1:0]            m_tdata
);
	import dips_pkg::*;

	localparam int SB = SPEED_BITS;
	localparam int OUT_PAD = OUT_W - 2 * ADJ_W - 2 * DRIVE_W;

	dips_cfg_t cfg;
	dips_adv_t adv;
	logic      v1_q, v2_q, v3_q, v4_q, out_v_q;

	logic signed [ADJ_W-1:0]   l_adj, r_adj;
	logic signed [DRIVE_W-1:0] l_drv, r_drv;

	dips_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage load strobes, from the output back to the input
	always_comb begin
		adv.out  = v4_q & (!out_v_q | m_tready);
		adv.s4   = v3_q & (!v4_q | adv.out);
		adv.s3   = v2_q & (!v3_q | adv.s4);
		adv.s2   = v1_q & (!v2_q | adv.s3);
		s_tready = !v1_q | adv.s2;
		adv.s1   = s_tvalid & s_tready;
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v1_q    <= adv.s1 | (v1_q & !adv.s2);
			v2_q    <= adv.s2 | (v2_q & !adv.s3);
			v3_q    <= adv.s3 | (v3_q & !adv.s4);
			v4_q    <= adv.s4 | (v4_q & !adv.out);
			out_v_q <= adv.out | (out_v_q & !m_tready);
		end
	end

	dips_wheel #(
		.FRAC_BITS  (FRAC_BITS),
		.SPEED_BITS (SPEED_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.en        (cfg.left_enable),
		.target    ($signed(s_tdata[SB-1:0])),
		.measured  ($signed(s_tdata[2*SB-1:SB])),
		.drive_in  ($signed(s_tdata[4*SB+DRIVE_W-1:4*SB])),
		.adjust    (l_adj),
		.drive_out (l_drv)
	);

	dips_wheel #(
		.FRAC_BITS  (FRAC_BITS),
		.SPEED_BITS (SPEED_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.en        (cfg.right_enable),
		.target    ($signed(s_tdata[3*SB-1:2*SB])),
		.measured  ($signed(s_tdata[4*SB-1:3*SB])),
		.drive_in  ($signed(s_tdata[4*SB+2*DRIVE_W-1:4*SB+DRIVE_W])),
		.adjust    (r_adj),
		.drive_out (r_drv)
	);

	// Pack the result
	assign m_tvalid = out_v_q;
	generate
		if (OUT_PAD > 0) begin : g_pad
			assign m_tdata = {{OUT_PAD{1'b0}}, r_drv, l_drv, r_adj, l_adj};
		end else begin : g_nopad
			assign m_tdata = {r_drv, l_drv, r_adj, l_adj};
		end
	endgenerate

endmodule

[src/dips_cfg.sv]
module dips_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dips_pkg::ADDR_W-1:0] paddr,
	input  logic [dips_pkg::DATA_W-1:0] pwdata,
	output logic [dips_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output dips_pkg::dips_cfg_t         cfg
);
	import dips_pkg::*;

	dips_cfg_t cfg_q;
	dips_reg_t idx;
	logic      wr_en;

	assign idx    = dips_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= PROP_GAIN_RST;
			cfg_q.integ_gain   <= INTEG_GAIN_RST;
			cfg_q.deriv_gain   <= DERIV_GAIN_RST;
			cfg_q.sum_limit    <= SUM_LIMIT_RST;
			cfg_q.left_enable  <= 1'b1;
			cfg_q.right_enable <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:    cfg_q.prop_gain    <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain   <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain   <= pwdata[GAIN_W-1:0];
				REG_SUM_LIMIT:    cfg_q.sum_limit    <= pwdata[LIM_W-1:0];
				REG_LEFT_ENABLE:  cfg_q.left_enable  <= pwdata[0];
				REG_RIGHT_ENABLE: cfg_q.right_enable <= pwdata[0];
				default:          ;
			endcase
		end
	end

	// Read back; unaligned addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (idx)
				REG_PROP_GAIN:    prdata = DATA_W'(cfg_q.prop_gain);
				REG_INTEG_GAIN:   prdata = DATA_W'(cfg_q.integ_gain);
				REG_DERIV_GAIN:   prdata = DATA_W'(cfg_q.deriv_gain);
				REG_SUM_LIMIT:    prdata = DATA_W'(cfg_q.sum_limit);
				REG_LEFT_ENABLE:  prdata = DATA_W'(cfg_q.left_enable);
				REG_RIGHT_ENABLE: prdata = DATA_W'(cfg_q.right_enable);
				default:          prdata = '0;
			endcase
		end
	end

endmodule

[src/dips_wheel.sv]
module dips_wheel #(
	parameter int FRAC_BITS  = dips_pkg::FRAC_BITS_DEF,
	parameter int SPEED_BITS = dips_pkg::SPEED_BITS_DEF,
	parameter int SUM_BITS   = dips_pkg::SUM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dips_pkg::dips_adv_t                 adv,
	input  dips_pkg::dips_cfg_t                 cfg,
	input  logic                                en,
	input  logic signed [SPEED_BITS-1:0]        target,
	input  logic signed [SPEED_BITS-1:0]        measured,
	input  logic signed [dips_pkg::DRIVE_W-1:0] drive_in,
	output logic signed [dips_pkg::ADJ_W-1:0]   adjust,
	output logic signed [dips_pkg::DRIVE_W-1:0] drive_out
);
	import dips_pkg::*;

	localparam int ERR_W  = SPEED_BITS + 1;
	localparam int D1_W   = SPEED_BITS + 2;
	localparam int D2_W   = SPEED_BITS + 3;
	localparam int PROD_W = D2_W + GAIN_W + 1;
	localparam int INC_W  = PROD_W + 2;
	localparam int EXT_W  = ((SUM_BITS > INC_W) ? SUM_BITS : INC_W) + 1;

	// Stage 1: input register
	logic signed [SPEED_BITS-1:0] tgt_s1, meas_s1;
	logic signed [DRIVE_W-1:0]    drive_s1, drive_s2, drive_s3, drive_s4;

	// Error history
	logic signed [ERR_W-1:0] e1_q, e2_q;
	logic signed [ERR_W-1:0] err;
	logic signed [D1_W-1:0]  d1;
	logic signed [D2_W-1:0]  d2;

	// Stage 2: products, stage 3: increment, stage 4: new sum
	logic signed [PROD_W-1:0]   p_s2, i_s2, d_s2;
	logic signed [INC_W-1:0]    inc_s3;
	logic signed [SUM_BITS-1:0] sum_q, sum_s4, sum_nxt;
	logic signed [EXT_W-1:0]    sum_wide;
	logic [EXT_W-SUM_BITS:0]    sum_hi;

	// Output stage
	logic signed [SUM_BITS-1:0] lim_pos, lim_neg, clamped, shifted;
	logic [SUM_BITS-ADJ_W:0]    adj_hi;
	logic signed [ADJ_W-1:0]    adj;
	logic signed [DRIVE_W:0]    drive_wide;
	logic signed [DRIVE_W-1:0]  drive_sat;
	logic signed [ADJ_W-1:0]    adjust_q;
	logic signed [DRIVE_W-1:0]  drive_q;

	assign adjust    = adjust_q;
	assign drive_out = drive_q;

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			tgt_s1   <= target;
			meas_s1  <= measured;
			drive_s1 <= drive_in;
		end
	end

	// Error and its first and second differences
	always_comb begin
		err = ERR_W'(meas_s1) - ERR_W'(tgt_s1);
		d1  = D1_W'(err) - D1_W'(e1_q);
		d2  = D2_W'(err) - (D2_W'(e1_q) <<< 1) + D2_W'(e2_q);
	end

	// Shift error history; clear it while disabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (adv.s2) begin
			if (en) begin
				e1_q <= err;
				e2_q <= e1_q;
			end else begin
				e1_q <= '0;
				e2_q <= '0;
			end
		end
	end

	// Gain products
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p_s2     <= $signed({1'b0, cfg.prop_gain}) * d1;
			i_s2     <= $signed({1'b0, cfg.integ_gain}) * err;
			d_s2     <= $signed({1'b0, cfg.deriv_gain}) * d2;
			drive_s2 <= drive_s1;
		end
	end

	// Sum the three terms
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			inc_s3   <= INC_W'(p_s2) + INC_W'(i_s2) + INC_W'(d_s2);
			drive_s3 <= drive_s2;
		end
	end

	// Saturating accumulate
	always_comb begin
		sum_wide = EXT_W'(sum_q) + EXT_W'(inc_s3);
		sum_hi   = sum_wide[EXT_W-1:SUM_BITS-1];
		if ((&sum_hi) || !(|sum_hi)) begin
			sum_nxt = sum_wide[SUM_BITS-1:0];
		end else if (sum_wide[EXT_W-1]) begin
			sum_nxt = {1'b1, {(SUM_BITS-1){1'b0}}};
		end else begin
			sum_nxt = {1'b0, {(SUM_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv.s4) begin
			sum_q <= en ? sum_nxt : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			sum_s4   <= en ? sum_nxt : '0;
			drive_s4 <= drive_s3;
		end
	end

	// Clamp, floor shift, saturate, add to drive
	always_comb begin
		lim_pos = $signed({{(SUM_BITS-LIM_W){1'b0}}, cfg.sum_limit});
		lim_neg = -lim_pos;
		if (sum_s4 > lim_pos) begin
			clamped = lim_pos;
		end else if (sum_s4 < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = sum_s4;
		end
		shifted = clamped >>> FRAC_BITS;
		adj_hi  = shifted[SUM_BITS-1:ADJ_W-1];
		if ((&adj_hi) || !(|adj_hi)) begin
			adj = shifted[ADJ_W-1:0];
		end else if (shifted[SUM_BITS-1]) begin
			adj = {1'b1, {(ADJ_W-1){1'b0}}};
		end else begin
			adj = {1'b0, {(ADJ_W-1){1'b1}}};
		end
		drive_wide = (DRIVE_W+1)'(drive_s4) + (DRIVE_W+1)'(adj);
		if (drive_wide[DRIVE_W] == drive_wide[DRIVE_W-1]) begin
			drive_sat = drive_wide[DRIVE_W-1:0];
		end else if (drive_wide[DRIVE_W]) begin
			drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.out) begin
			adjust_q <= adj;
			drive_q  <= drive_sat;
		end
	end

endmodule
